[sv/cskd_pkg.sv]
// ----------------------------------------------------------------------------
// cskd_pkg
// Shared constants and types for the at-most-K-distinct subarray counter.
// ----------------------------------------------------------------------------
package cskd_pkg;
  localparam int MAX_LEN  = 1024;
  localparam int VAL_W    = 32;
  localparam int ADDR_W   = $clog2(MAX_LEN);
  localparam int CNT_W    = 11;
  localparam int TOT_W    = 20;
  localparam logic [TOT_W-1:0] TOTAL_MAX = {TOT_W{1'b1}};

  // window store access for one cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;
endpackage

[sv/cskd_ifs.sv]
// ----------------------------------------------------------------------------
// cskd_ifs
// Valid/ready channels: input words, result words, config writes.
// ----------------------------------------------------------------------------
interface cskd_in_if;
  import cskd_pkg::*;
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] value;
  logic             first;
  modport source (output valid, value, first, input ready);
  modport sink   (input valid, value, first, output ready);
endinterface

interface cskd_out_if;
  import cskd_pkg::*;
  logic             valid;
  logic             ready;
  logic [TOT_W-1:0] total_count;
  logic [CNT_W-1:0] window_length;
  logic [CNT_W-1:0] distinct_now;
  logic             overflow;
  modport source (output valid, total_count, window_length, distinct_now, overflow,
                  input ready);
  modport sink   (input valid, total_count, window_length, distinct_now, overflow,
                  output ready);
endinterface

interface cskd_cfg_if;
  import cskd_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

[sv/count_subarrays_at_most_k_distinct_core.sv]
// ----------------------------------------------------------------------------
// count_subarrays_at_most_k_distinct_core
// Sliding-window counter of subarrays holding at most K distinct values.
// ----------------------------------------------------------------------------
// One word is taken at a time; in_ready is high only while the block is idle.
// Membership is decided by scanning the window store with a single comparator,
// one memory read and then one compare per window element. A new word may
// also drop elements from the left: each is fetched and the limit rechecked,
// and the remaining elements are scanned to check whether it still occurs.
// A word into an empty window skips the scan. The memory read port and the
// one comparator set the pace. Overflow words skip the scan as well and go
// straight to the output. No clearing pass is needed after reset.
module count_subarrays_at_most_k_distinct_core (
  input  logic       clk,
  input  logic       rst_n,
  cskd_in_if.sink    in_,
  cskd_out_if.source out_,
  cskd_cfg_if.sink   cfg_
);
  import cskd_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_LRD  = 3'd4;
  localparam logic [2:0] S_LLD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam logic [CNT_W-1:0] LEN_C = CNT_W'(MAX_LEN);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] left_r, left_nxt, right_r, right_nxt;
  logic [CNT_W-1:0] dist_r, dist_nxt, ptr_r, ptr_nxt, lim_r;
  logic [TOT_W-1:0] total_r, total_nxt;
  logic [VAL_W-1:0] key_r, key_nxt, val_r, val_nxt;
  logic             drop_r, drop_nxt, ovf_r, ovf_nxt;

  mem_req_t         mreq;
  logic [VAL_W-1:0] rdata;

  logic [CNT_W-1:0] lim, l_eff, r_eff, ptr_inc, left_inc, new_len;
  logic [TOT_W:0]   sum;
  logic             hit;

  cskd_win_mem u_mem (.clk(clk), .req(mreq), .rdata(rdata));

  assign lim      = (lim_r == '0) ? ONE_C : lim_r;
  assign ptr_inc  = ptr_r + ONE_C;
  assign left_inc = left_r + ONE_C;
  assign hit      = (rdata == key_r);
  assign new_len  = right_r + ONE_C - left_r;
  assign sum      = {1'b0, total_r} + (TOT_W+1)'(new_len);
  assign l_eff    = in_.first ? '0 : left_r;
  assign r_eff    = in_.first ? '0 : right_r;

  always_comb begin
    mreq.we    = (state_r == S_DONE);
    mreq.waddr = right_r[ADDR_W-1:0];
    mreq.wdata = val_r;
    mreq.raddr = (state_r == S_LRD) ? left_r[ADDR_W-1:0] : ptr_r[ADDR_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    dist_nxt  = dist_r;
    total_nxt = total_r;
    ptr_nxt   = ptr_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    drop_nxt  = drop_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_.valid) begin
          val_nxt  = in_.value;
          key_nxt  = in_.value;
          drop_nxt = 1'b0;
          ptr_nxt  = l_eff;
          ovf_nxt  = 1'b0;
          if (in_.first) begin
            left_nxt  = '0;
            right_nxt = '0;
            dist_nxt  = '0;
            total_nxt = '0;
          end
          if (r_eff >= LEN_C) begin
            ovf_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else if (l_eff >= r_eff) begin
            state_nxt = S_CHK;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        if (hit) begin
          if (drop_r) begin
            // dropped value still occurs further right
            left_nxt  = left_inc;
            state_nxt = S_CHK;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (ptr_inc >= right_r) begin
          if (drop_r) begin
            left_nxt = left_inc;
            dist_nxt = dist_r - ONE_C;
          end
          state_nxt = S_CHK;
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_RD;
        end
      end
      S_CHK: begin
        if (dist_r >= lim && left_r < right_r) begin
          state_nxt = S_LRD;
        end else begin
          dist_nxt  = dist_r + ONE_C;
          state_nxt = S_DONE;
        end
      end
      S_LRD: state_nxt = S_LLD;
      S_LLD: begin
        key_nxt  = rdata;
        ptr_nxt  = left_inc;
        drop_nxt = 1'b1;
        if (left_inc >= right_r) begin
          left_nxt  = left_inc;
          dist_nxt  = dist_r - ONE_C;
          state_nxt = S_CHK;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        right_nxt = right_r + ONE_C;
        total_nxt = sum[TOT_W] ? TOTAL_MAX : sum[TOT_W-1:0];
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      left_r  <= '0;
      right_r <= '0;
      dist_r  <= '0;
      total_r <= '0;
      lim_r   <= ONE_C;
      ovf_r   <= 1'b0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      dist_r  <= dist_nxt;
      total_r <= total_nxt;
      ovf_r   <= ovf_nxt;
      drop_r  <= drop_nxt;
      if (cfg_.valid) begin
        lim_r <= cfg_.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign in_.ready          = (state_r == S_IDLE);
  assign cfg_.ready         = 1'b1;
  assign out_.valid         = (state_r == S_OUT);
  assign out_.total_count   = total_r;
  assign out_.window_length = right_r - left_r;
  assign out_.distinct_now  = dist_r;
  assign out_.overflow      = ovf_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_.ready && out_.valid)) else $error("input and output both open");
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= right_r) else $error("left index passed right index");
  a_dist: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (dist_r <= right_r - left_r))
    else $error("distinct count exceeds window length");
  a_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_.valid && out_.overflow) |-> (right_r == LEN_C))
    else $error("overflow flagged below full length");
endmodule

[sv/cskd_win_mem.sv]
// ----------------------------------------------------------------------------
// cskd_win_mem
// Window value store: one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module cskd_win_mem (
  input  logic                       clk,
  input  cskd_pkg::mem_req_t         req,
  output logic [cskd_pkg::VAL_W-1:0] rdata
);
  import cskd_pkg::*;

  logic [VAL_W-1:0] mem [MAX_LEN];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule
